// ----- src/gmac_pkg.sv -----
package gmac_pkg;

    // default geometry of the accumulator store
    localparam int DEF_ROWS  = 16;
    localparam int DEF_MATS  = 8;
    localparam int DEF_LIMBS = 5;

    // field widths fixed by the item format
    localparam int ROW_W   = 4;
    localparam int MAT_W   = 3;
    localparam int LSEL_W  = 3;
    localparam int COEF_W  = 4;
    localparam int WORD_W  = 64;
    localparam int ELEMS   = WORD_W / COEF_W;

    // x^4 + x + 1
    localparam logic [COEF_W:0] GF_POLY = 5'h13;

    typedef enum logic {
        ACT_ACCUM = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

endpackage

// ----- src/gmac_scale.sv -----
module gmac_scale (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [gmac_pkg::COEF_W-1:0]      i_coefficient,
    input  logic [gmac_pkg::WORD_W-1:0]      i_vector_limb,
    output logic [gmac_pkg::WORD_W-1:0]      o_product
);

    logic [gmac_pkg::COEF_W-1:0] mult [gmac_pkg::COEF_W];
    logic [gmac_pkg::WORD_W-1:0] n_product;
    logic [gmac_pkg::WORD_W-1:0] r_product;

    // a * x with reduction by the field polynomial
    function automatic logic [gmac_pkg::COEF_W-1:0] times_x(
        input logic [gmac_pkg::COEF_W-1:0] v
    );
        logic [gmac_pkg::COEF_W:0] s;
        s = {v, 1'b0};
        if (s[gmac_pkg::COEF_W]) begin
            s = s ^ gmac_pkg::GF_POLY;
        end
        return s[gmac_pkg::COEF_W-1:0];
    endfunction

    // coefficient times x^b for each bit plane b
    always_comb begin
        mult[0] = i_coefficient;
        for (int b = 1; b < gmac_pkg::COEF_W; b++) begin
            mult[b] = times_x(mult[b-1]);
        end
    end

    always_comb begin
        logic [gmac_pkg::COEF_W-1:0] acc;
        n_product = '0;
        for (int j = 0; j < gmac_pkg::ELEMS; j++) begin
            acc = '0;
            for (int b = 0; b < gmac_pkg::COEF_W; b++) begin
                if (i_vector_limb[gmac_pkg::COEF_W*j + b]) begin
                    acc = acc ^ mult[b];
                end
            end
            n_product[gmac_pkg::COEF_W*j +: gmac_pkg::COEF_W] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= n_product;
        end
    end

    assign o_product = r_product;

endmodule

// ----- src/gf16_matrix_mul_accumulate_top.sv -----
// GF(16) multiply-accumulate over a store of ROWS*MATS*LIMBS 64-bit entries kept in one
// synchronous RAM. Each word names an entry by row, matrix and limb; accumulate XORs in
// coefficient times the sixteen packed elements of vector_limb, clear zeroes the entry,
// and every word returns the entry's new value (zero for an address outside the store,
// which then stays untouched). A word is taken every cycle while the result side keeps
// up, and its result is registered in two steps: the accepting edge captures the RAM
// read and the scaled limb, and once the result side is free the XOR, write-back and
// output register take place, with a forward path covering back-to-back hits on one entry.
// After reset the RAM is zeroed one entry per cycle, and o_in_ready stays low until that
// pass is done.
module gf16_matrix_mul_accumulate_top #(
    parameter int ROWS  = gmac_pkg::DEF_ROWS,
    parameter int MATS  = gmac_pkg::DEF_MATS,
    parameter int LIMBS = gmac_pkg::DEF_LIMBS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [gmac_pkg::ROW_W-1:0]    i_row,
    input  logic [gmac_pkg::MAT_W-1:0]    i_matrix_sel,
    input  logic [gmac_pkg::LSEL_W-1:0]   i_limb,
    input  logic [gmac_pkg::COEF_W-1:0]   i_coefficient,
    input  logic [gmac_pkg::WORD_W-1:0]   i_vector_limb,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gmac_pkg::WORD_W-1:0]   o_entry_value
);

    localparam int DEPTH = ROWS * MATS * LIMBS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    gmac_pkg::t_state r_state, n_state;

    logic [AW-1:0]               r_clr_addr;
    logic                        clr_active;
    logic                        clr_last;

    logic                        in_accept;
    logic                        in_range;
    logic [31:0]                 idx_full;
    logic [AW-1:0]               idx;

    logic                        r_s1_valid;
    logic                        r_s1_inrange;
    gmac_pkg::t_action           r_s1_action;
    logic [AW-1:0]               r_s1_addr;
    logic                        s1_go;

    logic [gmac_pkg::WORD_W-1:0] product;
    logic [gmac_pkg::WORD_W-1:0] r_rdata;
    logic [gmac_pkg::WORD_W-1:0] old_value;
    logic [gmac_pkg::WORD_W-1:0] new_value;

    logic                        r_fwd_valid;
    logic [AW-1:0]               r_fwd_addr;
    logic [gmac_pkg::WORD_W-1:0] r_fwd_data;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [gmac_pkg::WORD_W-1:0] mem_wdata;
    logic [gmac_pkg::WORD_W-1:0] mem [DEPTH];

    logic                        r_out_valid;
    logic [gmac_pkg::WORD_W-1:0] r_out_data;

    // ---------------- clearing pass state machine ----------------
    assign clr_last = (r_clr_addr == AW'(DEPTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            gmac_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    n_state = gmac_pkg::ST_RUN;
                end
            end
            gmac_pkg::ST_RUN: begin
                n_state = gmac_pkg::ST_RUN;
            end
            default: begin
                n_state = gmac_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            gmac_pkg::ST_CLEAR: clr_active = 1'b1;
            gmac_pkg::ST_RUN:   clr_active = 1'b0;
            default:            clr_active = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= gmac_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_active && !clr_last) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    // ---------------- address decode ----------------
    assign in_range = (32'(i_row) < 32'(ROWS)) && (32'(i_matrix_sel) < 32'(MATS))
                   && (32'(i_limb) < 32'(LIMBS));
    assign idx_full = (32'(i_row) * 32'(MATS) + 32'(i_matrix_sel)) * 32'(LIMBS)
                    + 32'(i_limb);
    assign idx      = idx_full[AW-1:0];

    // ---------------- handshake ----------------
    assign s1_go      = !r_out_valid || i_out_ready;
    assign o_in_ready = !clr_active && (!r_s1_valid || s1_go);
    assign in_accept  = i_in_valid && o_in_ready;

    gmac_scale u_scale (
        .i_clk         (i_clk),
        .i_en          (in_accept),
        .i_coefficient (i_coefficient),
        .i_vector_limb (i_vector_limb),
        .o_product     (product)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_inrange <= in_range;
            r_s1_action  <= gmac_pkg::t_action'(i_action);
            r_s1_addr    <= in_range ? idx : '0;
        end
    end

    // ---------------- read-modify-write ----------------
    // the read issued with a word misses a write landing on the same edge
    assign old_value = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rdata;
    assign new_value = (r_s1_action == gmac_pkg::ACT_CLEAR) ? '0 : (old_value ^ product);

    always_comb begin
        if (clr_active) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = r_s1_valid && s1_go && r_s1_inrange;
            mem_waddr = r_s1_addr;
            mem_wdata = new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_accept) begin
            r_rdata <= mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (clr_active) begin
            r_fwd_valid <= 1'b0;
        end else if (mem_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fwd_addr <= mem_waddr;
            r_fwd_data <= mem_wdata;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_s1_valid && s1_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_go) begin
            r_out_data <= r_s1_inrange ? new_value : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_entry_value = r_out_data;

    // ---------------- assertions ----------------
    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (32'(mem_waddr) < 32'(DEPTH)))
        else $error("write outside accumulator store");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_go && !r_s1_inrange) |=> (o_out_valid && o_entry_value == '0))
        else $error("out-of-range word returned nonzero value");

    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_go && r_s1_action == gmac_pkg::ACT_CLEAR)
        |=> (o_out_valid && o_entry_value == '0))
        else $error("clear returned nonzero value");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go)
        |-> (!mem_we ##1 (r_s1_valid && $stable(r_s1_addr))))
        else $error("stalled word lost or written early");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_active |-> (!in_accept && !r_s1_valid))
        else $error("word taken during clearing pass");

endmodule
